// ===== hdl/bgd_pkg.sv =====
package bgd_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;
  localparam int CLICK_WIDTH = 3;

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;
  typedef logic [CLICK_WIDTH-1:0] click_count_t;

  localparam cfg_word_t DEBOUNCE_MS_RESET   = CFG_WIDTH'(50);
  localparam cfg_word_t CLICK_MAX_MS_RESET  = CFG_WIDTH'(1000);
  localparam cfg_word_t CLICK_GAP_MS_RESET  = CFG_WIDTH'(400);
  localparam cfg_word_t LONG_PRESS_MS_RESET = CFG_WIDTH'(5000);

  localparam click_count_t CLICK_SAT         = CLICK_WIDTH'(7);
  localparam click_count_t CLICKS_FOR_DOUBLE = CLICK_WIDTH'(2);

  typedef enum logic [1:0] {
    REG_DEBOUNCE,
    REG_CLICK_MAX,
    REG_CLICK_GAP,
    REG_LONG_PRESS
  } reg_index_t;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t click_max_ms;
    cfg_word_t click_gap_ms;
    cfg_word_t long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic  pressed;
    logic  released;
    logic  long_fire;
    time_t hold_ms;
    time_t quiet_ms;
  } btn_status_t;

endpackage

// ===== hdl/bgd_if.sv =====
interface bgd_sample_if;
  logic valid;
  logic ready;
  logic a_down;
  logic b_down;

  modport source (output valid, output a_down, output b_down, input ready);
  modport sink (input valid, input a_down, input b_down, output ready);
endinterface

interface bgd_result_if;
  logic valid;
  logic ready;
  logic a_double_click;
  logic a_long_press;
  logic b_long_press;
  logic a_held;
  logic b_held;

  modport source (output valid, output a_double_click, output a_long_press,
                  output b_long_press, output a_held, output b_held, input ready);
  modport sink (input valid, input a_double_click, input a_long_press,
                input b_long_press, input a_held, input b_held, output ready);
endinterface

// ===== hdl/bgd_cfg.sv =====
module bgd_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bgd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [bgd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [bgd_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                  pready,
  output bgd_pkg::cfg_t                         cfg
);

  bgd_pkg::reg_index_t index;
  logic                wr_en;

  assign index  = bgd_pkg::reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= bgd_pkg::DEBOUNCE_MS_RESET;
      cfg.click_max_ms  <= bgd_pkg::CLICK_MAX_MS_RESET;
      cfg.click_gap_ms  <= bgd_pkg::CLICK_GAP_MS_RESET;
      cfg.long_press_ms <= bgd_pkg::LONG_PRESS_MS_RESET;
    end else if (wr_en) begin
      unique case (index)
        bgd_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= pwdata[bgd_pkg::CFG_WIDTH-1:0];
        bgd_pkg::REG_CLICK_MAX:  cfg.click_max_ms  <= pwdata[bgd_pkg::CFG_WIDTH-1:0];
        bgd_pkg::REG_CLICK_GAP:  cfg.click_gap_ms  <= pwdata[bgd_pkg::CFG_WIDTH-1:0];
        bgd_pkg::REG_LONG_PRESS: cfg.long_press_ms <= pwdata[bgd_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      bgd_pkg::REG_DEBOUNCE:   prdata = bgd_pkg::APB_DATA_WIDTH'(cfg.debounce_ms);
      bgd_pkg::REG_CLICK_MAX:  prdata = bgd_pkg::APB_DATA_WIDTH'(cfg.click_max_ms);
      bgd_pkg::REG_CLICK_GAP:  prdata = bgd_pkg::APB_DATA_WIDTH'(cfg.click_gap_ms);
      bgd_pkg::REG_LONG_PRESS: prdata = bgd_pkg::APB_DATA_WIDTH'(cfg.long_press_ms);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== hdl/bgd_button.sv =====
module bgd_button (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  level,
  input  bgd_pkg::time_t        time_now,
  input  bgd_pkg::cfg_word_t    debounce_ms,
  input  bgd_pkg::cfg_word_t    long_press_ms,
  output bgd_pkg::btn_status_t  status
);

  logic           last_level;
  logic           pressed;
  logic           long_fired;
  bgd_pkg::time_t press_stamp;
  bgd_pkg::time_t release_stamp;

  logic           last_level_next;
  logic           pressed_next;
  logic           long_fired_next;
  bgd_pkg::time_t press_stamp_next;
  bgd_pkg::time_t release_stamp_next;

  logic           rise_ok;
  logic           fall_ok;
  logic           long_fire;
  bgd_pkg::time_t since_release;
  bgd_pkg::time_t since_press;
  bgd_pkg::time_t hold_ms;
  bgd_pkg::time_t debounce_t;
  bgd_pkg::time_t long_t;

  always_comb begin
    debounce_t    = bgd_pkg::TIME_WIDTH'(debounce_ms);
    long_t        = bgd_pkg::TIME_WIDTH'(long_press_ms);
    since_release = time_now - release_stamp;
    since_press   = time_now - press_stamp;

    rise_ok = level & ~last_level & ~pressed & (since_release > debounce_t);
    fall_ok = ~level & last_level & pressed & (since_press > debounce_t);

    last_level_next    = level;
    pressed_next       = rise_ok | (pressed & ~fall_ok);
    press_stamp_next   = rise_ok ? time_now : press_stamp;
    release_stamp_next = fall_ok ? time_now : release_stamp;

    hold_ms   = time_now - press_stamp_next;
    long_fire = pressed_next & ~long_fired & (hold_ms >= long_t);
    long_fired_next = pressed_next & (long_fired | long_fire);

    status.pressed   = pressed_next;
    status.released  = fall_ok;
    status.long_fire = long_fire;
    status.hold_ms   = hold_ms;
    status.quiet_ms  = time_now - release_stamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      pressed       <= 1'b0;
      long_fired    <= 1'b0;
      press_stamp   <= '0;
      release_stamp <= '0;
    end else if (advance) begin
      last_level    <= last_level_next;
      pressed       <= pressed_next;
      long_fired    <= long_fired_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
    end
  end

endmodule

// ===== hdl/bgd_click.sv =====
module bgd_click (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  bgd_pkg::btn_status_t  status,
  input  bgd_pkg::cfg_word_t    click_max_ms,
  input  bgd_pkg::cfg_word_t    click_gap_ms,
  output logic                  double_click
);

  bgd_pkg::click_count_t click_count;
  bgd_pkg::click_count_t click_count_next;
  bgd_pkg::click_count_t counted;
  logic                  gap_closed;

  always_comb begin
    counted = click_count;
    if (status.released && (status.hold_ms < bgd_pkg::TIME_WIDTH'(click_max_ms))
        && (click_count < bgd_pkg::CLICK_SAT)) begin
      counted = click_count + bgd_pkg::CLICK_WIDTH'(1);
    end

    gap_closed = (counted != '0) & ~status.pressed
               & (status.quiet_ms > bgd_pkg::TIME_WIDTH'(click_gap_ms));
    double_click = gap_closed & (counted == bgd_pkg::CLICKS_FOR_DOUBLE);

    click_count_next = (gap_closed | status.long_fire) ? '0 : counted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      click_count <= '0;
    end else if (advance) begin
      click_count <= click_count_next;
    end
  end

endmodule

// ===== hdl/button_gesture_detector_unit.sv =====
// Two-button gesture detector. Each sample transfer is one millisecond tick carrying the
// levels of buttons A and B; each one yields exactly one result transfer with the double
// click and long press events of that tick and the debounced held states. A sample is
// taken in every clock cycle while the result register is empty or being drained, so the
// block sustains one tick per cycle and registers the result as it takes a sample. Edges,
// debounce, click counting and long press are evaluated combinationally from the stored
// per-button state. The four 16-bit millisecond thresholds sit behind the APB port at
// byte addresses 0x0, 0x4, 0x8 and 0xC and should be written only while the block is idle.
module button_gesture_detector_unit (
  input  logic                                clk,
  input  logic                                rst,
  bgd_sample_if.sink                          sample,
  bgd_result_if.source                        result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bgd_pkg::APB_ADDR_WIDTH-1:0]  paddr,
  input  logic [bgd_pkg::APB_DATA_WIDTH-1:0]  pwdata,
  output logic [bgd_pkg::APB_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  bgd_pkg::cfg_t        cfg;
  bgd_pkg::btn_status_t a_status;
  bgd_pkg::btn_status_t b_status;
  bgd_pkg::time_t       time_now;
  logic                 advance;
  logic                 a_double;
  logic                 res_valid;

  assign sample.ready = ~res_valid | result.ready;
  assign advance      = sample.valid & sample.ready;

  bgd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bgd_button u_button_a (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .level         (sample.a_down),
    .time_now      (time_now),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .status        (a_status)
  );

  bgd_button u_button_b (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .level         (sample.b_down),
    .time_now      (time_now),
    .debounce_ms   (cfg.debounce_ms),
    .long_press_ms (cfg.long_press_ms),
    .status        (b_status)
  );

  bgd_click u_click (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .status       (a_status),
    .click_max_ms (cfg.click_max_ms),
    .click_gap_ms (cfg.click_gap_ms),
    .double_click (a_double)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (advance) begin
        time_now <= time_now + bgd_pkg::TIME_WIDTH'(1);
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.a_double_click <= a_double;
      result.a_long_press   <= a_status.long_fire;
      result.b_long_press   <= b_status.long_fire;
      result.a_held         <= a_status.pressed;
      result.b_held         <= b_status.pressed;
    end
  end

  assign result.valid = res_valid;

endmodule
